// ===== rtl/line_command_recognizer_unit_defines.svh =====
// Assertion macros shared by the RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef LINE_COMMAND_RECOGNIZER_UNIT_DEFINES_SVH
`define LINE_COMMAND_RECOGNIZER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Clocked check, idle while reset is asserted.
`define LCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define LCR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LCR_ASSERT(lbl, prop, msg)
`define LCR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/lcr_pkg.sv =====
package lcr_pkg;

  localparam int KW_COUNT = 7;
  localparam int CODE_W   = 3;
  localparam int CMP_W    = 4;

  localparam logic [CODE_W-1:0] CODE_RESET    = 3'd0;
  localparam logic [CODE_W-1:0] CODE_APP      = 3'd1;
  localparam logic [CODE_W-1:0] CODE_RUN_GO   = 3'd2;
  localparam logic [CODE_W-1:0] CODE_DATA_RDY = 3'd3;
  localparam logic [CODE_W-1:0] CODE_RECEIVED = 3'd4;
  localparam logic [CODE_W-1:0] CODE_CONTINUE = 3'd5;
  localparam logic [CODE_W-1:0] CODE_STOP     = 3'd6;
  localparam logic [CODE_W-1:0] CODE_UNKNOWN  = 3'd7;

  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  localparam logic [CMP_W-1:0] CMP_MAX = 4'd15;

  // keyword text, first char in the top byte; '.' pads past the keyword end
  typedef logic [15:0][7:0] kw_text_t;
  typedef logic [CMP_W-1:0] kw_len_t;

  localparam kw_text_t KW_TEXT [KW_COUNT] = '{
    "RESET...........",
    "APP.............",
    "RUN_START.......",
    "READY_FOR_DATA..",
    "RECEIVED........",
    "CONTINUE........",
    "STOP............"
  };

  localparam kw_len_t KW_LEN [KW_COUNT] = '{
    4'd5, 4'd3, 4'd9, 4'd14, 4'd8, 4'd8, 4'd4
  };

  typedef struct packed {
    logic [KW_COUNT-1:0] keep;  // candidates after this byte
    logic [CODE_W-1:0]   code;  // code of the line as it stands
  } match_t;

endpackage

// ===== rtl/line_command_recognizer_unit.sv =====
// Channel  Dir  Handshake           Word
// in       in   in_valid/in_stall   in_rx_byte[7:0]       one received byte
// out      out  out_valid/out_stall out_command_code[2:0] keyword code, 7 unknown
//
// One byte per cycle while in_stall is low; a code is registered into the output slot, or into the skid if it is held.
// Line state updates in the accept cycle through one keyword compare per lane.
// A two-deep output (register plus skid) keeps input flowing under out_stall;
// in_stall rises only while the skid holds a word.
// Synchronous active-low reset clears the line state and the valid flags of both output slots.
module line_command_recognizer_unit #(
  parameter int LINE_CAPACITY = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_command_code
);
  import lcr_pkg::*;

`include "line_command_recognizer_unit_defines.svh"

  localparam int LEN_W = $clog2(LINE_CAPACITY);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CAPACITY - 1);

  // line state
  logic [LEN_W-1:0]    line_len_r, line_len_nxt;
  logic [CMP_W-1:0]    cmp_r, cmp_nxt;
  logic                zero_seen_r, zero_seen_nxt;
  logic [KW_COUNT-1:0] cand_r, cand_nxt;

  // output register and skid
  logic              out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0] out_code_r, out_code_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  logic [CODE_W-1:0] skid_code_r, skid_code_nxt;

  logic   in_acc;
  logic   out_take;
  logic   is_term;
  logic   res_vld;
  match_t match;

  assign in_stall         = skid_valid_r;
  assign out_valid        = out_valid_r;
  assign out_command_code = out_code_r;

  assign in_acc   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;
  assign is_term  = (in_rx_byte == CHAR_LF) || (in_rx_byte == CHAR_CR);

  lcr_match u_match (
    .cand    (cand_r),
    .cmp_len (cmp_r),
    .rx_byte (in_rx_byte),
    .match   (match)
  );

  // line tracking
  always_comb begin
    line_len_nxt  = line_len_r;
    cmp_nxt       = cmp_r;
    zero_seen_nxt = zero_seen_r;
    cand_nxt      = cand_r;
    res_vld       = 1'b0;
    if (in_acc) begin
      if (is_term) begin
        // empty line: nothing emitted, nothing changes
        if (line_len_r != '0) begin
          res_vld       = 1'b1;
          line_len_nxt  = '0;
          cmp_nxt       = '0;
          zero_seen_nxt = 1'b0;
          cand_nxt      = '1;
        end
      end else if (line_len_r != LEN_MAX) begin
        line_len_nxt = line_len_r + LEN_W'(1);
        // bytes from the first NUL on are counted but not compared
        if (!zero_seen_r) begin
          if (in_rx_byte == CHAR_NUL) begin
            zero_seen_nxt = 1'b1;
          end else begin
            cand_nxt = match.keep;
            if (cmp_r != CMP_MAX) begin
              cmp_nxt = cmp_r + CMP_W'(1);
            end
          end
        end
      end else begin
        // overflow: drop the byte and restart the line
        line_len_nxt  = '0;
        cmp_nxt       = '0;
        zero_seen_nxt = 1'b0;
        cand_nxt      = '1;
      end
    end
  end

  // output register with skid
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_code_nxt   = out_code_r;
    skid_valid_nxt = skid_valid_r;
    skid_code_nxt  = skid_code_r;
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        // input is stalled here, so no new result competes
        out_valid_nxt  = 1'b1;
        out_code_nxt   = skid_code_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_vld;
        out_code_nxt  = match.code;
      end
    end else if (res_vld) begin
      skid_valid_nxt = 1'b1;
      skid_code_nxt  = match.code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r   <= '0;
      cmp_r        <= '0;
      zero_seen_r  <= 1'b0;
      cand_r       <= '1;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      line_len_r   <= line_len_nxt;
      cmp_r        <= cmp_nxt;
      zero_seen_r  <= zero_seen_nxt;
      cand_r       <= cand_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_code_r  <= out_code_nxt;
    skid_code_r <= skid_code_nxt;
  end

  `LCR_ASSERT(a_skid_behind_out, skid_valid_r |-> out_valid_r, "skid full, output empty")
  `LCR_ASSERT(a_cand_bounds_cmp, (cand_r != '0) |-> (cmp_r != CMP_MAX), "live candidate")
  `LCR_ASSERT(a_cmp_le_len, LEN_W'(cmp_r) <= line_len_r, "compared count past length")
  `LCR_ASSERT(a_zero_nonempty, zero_seen_r |-> (line_len_r != '0), "NUL flag on empty line")
  `LCR_ASSERT(a_stall_holds_word, (out_valid_r && out_stall) |=> $stable(out_code_r), "word moved")

endmodule

// ===== rtl/lcr_match.sv =====
module lcr_match (
  input  logic [lcr_pkg::KW_COUNT-1:0] cand,
  input  logic [lcr_pkg::CMP_W-1:0]    cmp_len,
  input  logic [7:0]                   rx_byte,
  output lcr_pkg::match_t              match
);
  import lcr_pkg::*;

  always_comb begin
    match.keep = '0;
    match.code = CODE_UNKNOWN;
    for (int k = 0; k < KW_COUNT; k++) begin
      // byte index i sits at element 15-i, i.e. ~cmp_len
      if (cand[k] && (cmp_len < KW_LEN[k]) && (KW_TEXT[k][~cmp_len] == rx_byte)) begin
        match.keep[k] = 1'b1;
      end
    end
    // lowest keyword index wins
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (cand[k] && (cmp_len == KW_LEN[k])) begin
        match.code = CODE_W'(k);
      end
    end
  end

endmodule

// ===== sim/line_command_recognizer_unit_tb.sv =====
module line_command_recognizer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lcr_pkg::*;

  localparam int LINE_CAP    = 128;    // line holds LINE_CAP-1 bytes at most
  localparam int HOLD_CYCLES = 80;     // long receiver hold-off, fills the output
  localparam int DRAIN_LIMIT = 5000;   // cycles allowed for codes still in flight
  localparam int SETTLE      = 10;     // extra wait once no codes are owed
  localparam int MAX_REPORTS = 50;

  logic       clk              = 1'b0;
  logic       rst_n            = 1'b0;
  logic       in_valid         = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte       = 8'h00;
  logic       out_valid;
  logic       out_stall        = 1'b0;
  logic [2:0] out_command_code;

  // traffic shaping, set by the test tasks
  bit idle_on  = 1'b1;   // sender leaves random gaps
  bit stall_on = 1'b1;   // receiver stalls at random
  bit hold_req = 1'b0;   // ask the receiver for one long hold-off

  int bytes_sent = 0;
  int err_count  = 0;

  // predicted line state: length, compared bytes, NUL flag, keyword candidates
  int unsigned         line_len;
  int unsigned         cmp_len;
  bit                  nul_seen;
  logic [KW_COUNT-1:0] cands;
  logic [2:0]          code_q[$];   // codes owed by the block, oldest first

  string keyword_spelling[KW_COUNT] = '{
    "RESET", "APP", "RUN_START", "READY_FOR_DATA", "RECEIVED", "CONTINUE", "STOP"
  };
  logic [2:0] keyword_code[KW_COUNT] = '{
    CODE_RESET, CODE_APP, CODE_RUN_GO, CODE_DATA_RDY,
    CODE_RECEIVED, CODE_CONTINUE, CODE_STOP
  };

  line_command_recognizer_unit #(
    .LINE_CAPACITY(LINE_CAP)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_command_code(out_command_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Line predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_line();
    line_len = 0;
    cmp_len  = 0;
    nul_seen = 1'b0;
    cands    = '1;
  endfunction

  // Advance the predicted line by one accepted word; a terminator on a
  // non-empty line queues the code of the line.
  function automatic void predict_byte(input logic [7:0] b);
    logic [KW_COUNT-1:0] keep;
    logic [2:0]          code;
    if (b == CHAR_LF || b == CHAR_CR) begin
      if (line_len != 0) begin
        code = CODE_UNKNOWN;
        // first keyword still a candidate whose full length was compared
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
          if (cands[k] && cmp_len == keyword_spelling[k].len()) code = keyword_code[k];
        end
        code_q.push_back(code);
        clear_line();
      end
    end else if (line_len < LINE_CAP - 1) begin
      line_len++;
      // bytes from the first NUL on count for length only
      if (!nul_seen) begin
        if (b == CHAR_NUL) begin
          nul_seen = 1'b1;
        end else begin
          keep = '0;
          for (int k = 0; k < KW_COUNT; k++) begin
            if (cands[k] && cmp_len < keyword_spelling[k].len() &&
                8'(keyword_spelling[k][cmp_len]) == b) keep[k] = 1'b1;
          end
          cands = keep;
          if (cmp_len < CMP_MAX) cmp_len++;
        end
      end
    end else begin
      // full line: the word is dropped and the line starts over
      clear_line();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors: sampled at the rising edge, before the block's own updates land
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) predict_byte(in_rx_byte);
  end

  always @(posedge clk) begin
    logic [2:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (code_q.size() == 0) begin
        report_mismatch($sformatf("code %0d with none owed", out_command_code));
      end else begin
        want = code_q.pop_front();
        if (out_command_code !== want)
          report_mismatch($sformatf("command_code %0d, predicted %0d",
                                    out_command_code, want));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or one long hold-off counted here on request
  // ---------------------------------------------------------------------------

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  <= 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= stall_on && ($urandom_range(99) < 37);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one word, hold it until taken, then maybe idle. Entered and left
  // at a rising edge; with no gap valid simply stays high for the next word.
  task automatic send_byte(input logic [7:0] b);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (idle_on && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 37);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(8'(s[i]));
  endtask

  // any byte but a line terminator
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CHAR_LF || b == CHAR_CR);
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // every keyword, ended by LF and by CR in turn
  task automatic test_keywords();
    for (int k = 0; k < KW_COUNT; k++) begin
      send_text(keyword_spelling[k]);
      send_byte((k % 2 == 0) ? CHAR_LF : CHAR_CR);
    end
  endtask

  task automatic test_edge_lines();
    // empty lines emit nothing; CR LF after a word gives one code
    send_byte(CHAR_LF);
    send_byte(CHAR_CR);
    send_text("STOP");
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    // NUL first: unknown even with a keyword behind it
    send_byte(CHAR_NUL);
    send_text("APP");
    send_byte(CHAR_LF);
    // NUL ends the compare: RESET matches, RUN does not
    send_text("RESET");
    send_byte(CHAR_NUL);
    send_text("XYZ");
    send_byte(CHAR_LF);
    send_text("RUN");
    send_byte(CHAR_NUL);
    send_text("_START");
    send_byte(CHAR_CR);
    // prefix, extension, saturation past every keyword, top byte value
    send_text("RECEIVE");
    send_byte(CHAR_LF);
    send_text("STOPS");
    send_byte(CHAR_LF);
    send_text("READY_FOR_DATA_READY");
    send_byte(CHAR_LF);
    send_byte(8'hFF);
    send_byte(CHAR_LF);
    // exactly full line still recognized: APP then NUL padding
    send_text("APP");
    repeat (LINE_CAP - 4) send_byte(CHAR_NUL);
    send_byte(CHAR_LF);
    // one word past full clears the line: the terminator finds it empty
    send_text("APP");
    repeat (LINE_CAP - 4) send_byte(CHAR_NUL);
    send_byte(8'h5A);
    send_byte(CHAR_LF);
    // full line of text, the overflow word dropped, then a fresh keyword
    repeat (LINE_CAP - 1) send_byte(8'h58);
    send_byte(8'h59);
    send_text("STOP");
    send_byte(CHAR_LF);
  endtask

  // receiver holds off while the sender streams short lines back to back
  task automatic test_back_pressure();
    idle_on = 1'b0;
    hold_req <= 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_text(keyword_spelling[i % KW_COUNT]);
      send_byte(CHAR_LF);
    end
    idle_on = 1'b1;
  endtask

  // mostly keywords with random damage, some noise, rare overlong lines
  task automatic test_random_lines(input int byte_goal);
    logic [7:0] chars[$];
    int         start;
    int         pick;
    string      kw;
    start = bytes_sent;
    while (bytes_sent - start < byte_goal) begin
      chars.delete();
      pick = $urandom_range(99);
      kw   = keyword_spelling[$urandom_range(KW_COUNT - 1)];
      for (int i = 0; i < kw.len(); i++) chars.push_back(8'(kw[i]));
      if (pick < 40) begin
        // clean keyword
      end else if (pick < 50) begin
        chars[$urandom_range(chars.size() - 1)] = text_byte();
      end else if (pick < 60) begin
        repeat ($urandom_range(1, chars.size() - 1)) void'(chars.pop_back());
      end else if (pick < 68) begin
        repeat ($urandom_range(1, 3)) chars.push_back(text_byte());
      end else if (pick < 78) begin
        chars.insert($urandom_range(0, chars.size()), CHAR_NUL);
        repeat ($urandom_range(0, 4)) chars.push_back(text_byte());
      end else if (pick < 95) begin
        // noise, terminators included
        chars.delete();
        repeat ($urandom_range(1, 20)) chars.push_back(8'($urandom_range(255)));
      end else if (pick < 98) begin
        // around the line limit, both sides of it
        chars.delete();
        repeat ($urandom_range(LINE_CAP - 10, LINE_CAP + 12)) chars.push_back(text_byte());
      end else begin
        chars.delete();
      end
      foreach (chars[i]) send_byte(chars[i]);
      send_byte($urandom_range(1) ? CHAR_LF : CHAR_CR);
      if ($urandom_range(9) == 0) send_byte($urandom_range(1) ? CHAR_LF : CHAR_CR);
    end
  endtask

  // full rate on both sides for a while
  task automatic test_steady_stream(input int byte_goal);
    idle_on  = 1'b0;
    stall_on = 1'b0;
    test_random_lines(byte_goal);
    idle_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    int guard;
    clear_line();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_keywords();
    test_edge_lines();
    test_back_pressure();
    test_random_lines(190);
    test_steady_stream(80);
    test_random_lines(70);
    in_valid <= 1'b0;

    guard = 0;
    while (code_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE) @(posedge clk);
    if (code_q.size() != 0) report_mismatch($sformatf("%0d codes never came", code_q.size()));

    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
